[rtl/core/mqlf_pkg.sv]
// shared types, codes and default sizes for the multi-queue linked fifo
`timescale 1ns / 1ps

package mqlf_pkg;

   localparam int NUM_QUEUES_DEF = 3;
   localparam int POOL_DEPTH_DEF = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int QID_WIDTH      = 2;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic push_exec;
      logic pop_read;
      logic pop_exec;
      logic fail_exec;
      logic out_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_pop;
      logic push_ok;
      logic pop_ok;
      logic out_free;
   } dp_stat_type;

endpackage

[rtl/core/mqlf_req_if.sv]
// request channel: operation, queue and value
`timescale 1ns / 1ps

interface mqlf_req_if
   import mqlf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [QID_WIDTH-1:0]         queue_id;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, mode, queue_id, value, input ready);
   modport sink   (input valid, mode, queue_id, value, output ready);
endinterface

[rtl/core/mqlf_rsp_if.sv]
// response channel: popped value and status
`timescale 1ns / 1ps

interface mqlf_rsp_if
   import mqlf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] popped_value;
   logic [1:0]                   status;

   modport source (output valid, popped_value, status, input ready);
   modport sink   (input valid, popped_value, status, output ready);
endinterface

[rtl/core/multi_queue_linked_fifo_top.sv]
// top level of the multi-queue linked fifo: controller plus datapath
// flow: a request is captured along with a synchronous read of its queue pointers, then
//   executed as a push or a refusal, or on a successful pop the head node is read and
//   popped; the response load waits while the previous response is still held
// one item at a time: a new request is accepted only after the response is loaded
// reset: synchronous, clears queue flags, free list, fresh-node count and output valid
`timescale 1ns / 1ps

module multi_queue_linked_fifo_top
   import mqlf_pkg::*;
#(
   parameter int NUM_QUEUES = NUM_QUEUES_DEF,
   parameter int POOL_DEPTH = POOL_DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
   input  logic       clock,
   input  logic       reset,
   mqlf_req_if.sink   req_chan,
   mqlf_rsp_if.source rsp_chan
);

   cmd_type     cmd;
   dp_stat_type stat;

   mqlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mqlf_dp #(
      .NUM_QUEUES (NUM_QUEUES),
      .POOL_DEPTH (POOL_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_chan.mode),
      .req_queue_id     (req_chan.queue_id),
      .req_value        (req_chan.value),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_status       (rsp_chan.status)
   );

endmodule

[rtl/core/mqlf_ctrl.sv]
// controller state machine sequencing one queue operation at a time
`timescale 1ns / 1ps

module mqlf_ctrl
   import mqlf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_POP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            // queue pointers and free-list link are now read
            if (stat.is_pop) begin
               if (stat.pop_ok) begin
                  cmd.pop_read = 1'b1;
                  state_in     = S_POP;
               end else begin
                  cmd.fail_exec = 1'b1;
                  state_in      = S_DONE;
               end
            end else begin
               if (stat.push_ok) begin
                  cmd.push_exec = 1'b1;
               end else begin
                  cmd.fail_exec = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_POP: begin
            cmd.pop_exec = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/mqlf_dp.sv]
// datapath: queue pointer memories, node pool memories, free list and output register
`timescale 1ns / 1ps

module mqlf_dp
   import mqlf_pkg::*;
#(
   parameter int NUM_QUEUES = NUM_QUEUES_DEF,
   parameter int POOL_DEPTH = POOL_DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output dp_stat_type                  stat,
   input  logic                         req_mode,
   input  logic [QID_WIDTH-1:0]         req_queue_id,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_popped_value,
   output logic [1:0]                   rsp_status
);

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);

   // queue pointer memories and node pool
   logic [PW-1:0]         head_mem [NUM_QUEUES];
   logic [PW-1:0]         tail_mem [NUM_QUEUES];
   logic [DATA_WIDTH-1:0] node_data_mem [POOL_DEPTH];
   logic [PW-1:0]         node_next_mem [POOL_DEPTH];

   logic [PW-1:0]         head_rd_ff, tail_rd_ff, next_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;

   logic                  mode_ff;
   logic [QID_WIDTH-1:0]  qid_ff;
   logic [DATA_WIDTH-1:0] value_ff;

   logic                  nonempty_ff [NUM_QUEUES];
   logic [CW-1:0]         fresh_ff;
   logic [PW-1:0]         free_head_ff;
   logic                  free_ne_ff;

   logic [DATA_WIDTH-1:0] res_data_ff;
   status_type            res_status_ff;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   status_type            rsp_status_ff;

   logic [QW-1:0]         q_idx, req_q_idx;
   logic                  q_valid, cur_ne, have_node;
   logic [PW-1:0]         new_node, node_rd_addr;
   logic                  next_we, head_we;
   logic [PW-1:0]         next_wr_addr, next_wr_data, head_wr_data;

   assign req_q_idx = QW'(req_queue_id);
   assign q_idx     = QW'(qid_ff);
   assign q_valid   = (32'(qid_ff) < NUM_QUEUES);
   assign cur_ne    = q_valid && nonempty_ff[q_idx];
   assign have_node = free_ne_ff || (fresh_ff != CW'(POOL_DEPTH));
   assign new_node  = free_ne_ff ? free_head_ff : PW'(fresh_ff);

   assign stat.is_pop   = (mode_ff == MODE_POP);
   assign stat.push_ok  = q_valid && have_node;
   assign stat.pop_ok   = cur_ne;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // free-list link on capture, head node on pop
   assign node_rd_addr = cmd.capture ? free_head_ff : head_rd_ff;

   assign next_we      = (cmd.push_exec && cur_ne) || cmd.pop_exec;
   assign next_wr_addr = cmd.pop_exec ? head_rd_ff : tail_rd_ff;
   assign next_wr_data = cmd.pop_exec ? (free_ne_ff ? free_head_ff : head_rd_ff) : new_node;
   assign head_we      = (cmd.push_exec && !cur_ne) ||
                         (cmd.pop_exec && (head_rd_ff != tail_rd_ff));
   assign head_wr_data = cmd.pop_exec ? next_rd_ff : new_node;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_mode;
         qid_ff     <= req_queue_id;
         value_ff   <= req_value;
         head_rd_ff <= head_mem[req_q_idx];
         tail_rd_ff <= tail_mem[req_q_idx];
      end
      if (head_we) begin
         head_mem[q_idx] <= head_wr_data;
      end
      if (cmd.push_exec) begin
         tail_mem[q_idx] <= new_node;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.pop_read) begin
         next_rd_ff <= node_next_mem[node_rd_addr];
         data_rd_ff <= node_data_mem[node_rd_addr];
      end
      if (cmd.push_exec) begin
         node_data_mem[new_node] <= value_ff;
      end
      if (next_we) begin
         node_next_mem[next_wr_addr] <= next_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            nonempty_ff[i] <= 1'b0;
         end
         fresh_ff     <= '0;
         free_head_ff <= '0;
         free_ne_ff   <= 1'b0;
      end else if (cmd.push_exec) begin
         nonempty_ff[q_idx] <= 1'b1;
         if (free_ne_ff) begin
            // a node linking to itself ends the free list
            if (next_rd_ff == free_head_ff) begin
               free_ne_ff <= 1'b0;
            end else begin
               free_head_ff <= next_rd_ff;
            end
         end else begin
            fresh_ff <= fresh_ff + CW'(1);
         end
      end else if (cmd.pop_exec) begin
         if (head_rd_ff == tail_rd_ff) begin
            nonempty_ff[q_idx] <= 1'b0;
         end
         free_head_ff <= head_rd_ff;
         free_ne_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_exec) begin
         res_data_ff   <= '0;
         res_status_ff <= ST_PUSHED;
      end else if (cmd.pop_exec) begin
         res_data_ff   <= data_rd_ff;
         res_status_ff <= ST_POPPED;
      end else if (cmd.fail_exec) begin
         res_data_ff   <= '0;
         res_status_ff <= (mode_ff == MODE_POP) ? ST_EMPTY : ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff   <= res_data_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_data_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
